// ===== rtl/bspm_pkg.sv =====
`default_nettype none
package bspm_pkg;

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_POP   = 3'd1;
  localparam logic [2:0] CMD_TOP   = 3'd2;
  localparam logic [2:0] CMD_PEEK  = 3'd3;
  localparam logic [2:0] CMD_MAX   = 3'd4;
  localparam logic [2:0] CMD_MIN   = 3'd5;
  localparam logic [2:0] CMD_CLEAR = 3'd6;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_BADPEEK = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [1:0]         status;
    logic [10:0]        fill_count;
  } rsp_t;

  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_DOWN,
    SHIFT_UP
  } shift_mode_t;

  typedef struct packed {
    shift_mode_t        mode;
    logic signed [31:0] push_data;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/bspm_cell.sv =====
`default_nettype none
module bspm_cell (
  input  wire logic                clk,
  input  wire bspm_pkg::cell_ctl_t ctl,
  input  wire logic signed [31:0]  from_above,
  input  wire logic signed [31:0]  from_below,
  output logic signed [31:0]       value
);

  always_ff @(posedge clk) begin
    case (ctl.mode)
      bspm_pkg::SHIFT_DOWN: begin
        value <= from_above;
      end
      bspm_pkg::SHIFT_UP: begin
        value <= from_below;
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bspm_ctrl.sv =====
`default_nettype none
module bspm_ctrl #(
  parameter int DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire bspm_pkg::req_t      req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output bspm_pkg::rsp_t           rsp,
  input  wire logic signed [31:0]  head,
  output bspm_pkg::cell_ctl_t      cell_ctl
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  bspm_pkg::state_t   state;
  bspm_pkg::state_t   state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [IW-1:0]      step;
  logic [IW-1:0]      offset;
  logic               scan_max;
  logic               peek_op;
  logic signed [31:0] best;
  logic signed [31:0] best_next;
  bspm_pkg::rsp_t     rsp_next;
  logic               load_rsp;
  logic               start_scan;
  logic               accept;
  logic               empty;
  logic               full;
  logic               last;
  logic               bad_peek;
  logic               take;

  assign req_ready = (state == bspm_pkg::S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign last      = (step == IW'(DEPTH - 1));
  assign bad_peek  = req.operand[31] || ($unsigned(req.operand) >= 32'(count));

  // ring rotates up, so the head holds entry number step
  always_comb begin
    if (peek_op) begin
      take = (step == offset);
    end else if (step == '0) begin
      take = 1'b1;
    end else if (CW'(step) < count) begin
      take = scan_max ? (head > best) : (head < best);
    end else begin
      take = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bspm_pkg::S_IDLE: begin
        if (start_scan) state_next = bspm_pkg::S_SCAN;
      end
      bspm_pkg::S_SCAN: begin
        if (last) state_next = bspm_pkg::S_IDLE;
      end
      default: begin
        state_next = bspm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_next         = count;
    load_rsp           = 1'b0;
    start_scan         = 1'b0;
    best_next          = best;
    rsp_next           = '0;
    cell_ctl.mode      = bspm_pkg::SHIFT_HOLD;
    cell_ctl.push_data = req.operand;
    case (state)
      bspm_pkg::S_IDLE: begin
        if (accept) begin
          load_rsp = 1'b1;
          case (req.command)
            bspm_pkg::CMD_PUSH: begin
              if (full) begin
                rsp_next.status = bspm_pkg::STAT_FULL;
              end else begin
                cell_ctl.mode = bspm_pkg::SHIFT_DOWN;
                count_next    = count + CW'(1);
              end
            end
            bspm_pkg::CMD_POP: begin
              if (empty) begin
                rsp_next.status = bspm_pkg::STAT_EMPTY;
              end else begin
                cell_ctl.mode = bspm_pkg::SHIFT_UP;
                count_next    = count - CW'(1);
              end
            end
            bspm_pkg::CMD_TOP: begin
              if (empty) begin
                rsp_next.status = bspm_pkg::STAT_EMPTY;
              end else begin
                rsp_next.read_data = head;
              end
            end
            bspm_pkg::CMD_PEEK: begin
              if (bad_peek) begin
                rsp_next.status = bspm_pkg::STAT_BADPEEK;
              end else begin
                load_rsp   = 1'b0;
                start_scan = 1'b1;
              end
            end
            bspm_pkg::CMD_MAX, bspm_pkg::CMD_MIN: begin
              if (empty) begin
                rsp_next.status = bspm_pkg::STAT_EMPTY;
              end else begin
                load_rsp   = 1'b0;
                start_scan = 1'b1;
              end
            end
            bspm_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      bspm_pkg::S_SCAN: begin
        cell_ctl.mode = bspm_pkg::SHIFT_UP;
        if (take) best_next = head;
        if (last) begin
          load_rsp           = 1'b1;
          rsp_next.read_data = best_next;
        end
      end
      default: begin
      end
    endcase
    rsp_next.fill_count = 11'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bspm_pkg::S_IDLE;
      count     <= '0;
      step      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (start_scan) begin
        step <= '0;
      end else if (state == bspm_pkg::S_SCAN) begin
        step <= step + IW'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    best <= best_next;
    if (load_rsp) rsp <= rsp_next;
    if (accept) begin
      scan_max <= (req.command == bspm_pkg::CMD_MAX);
      peek_op  <= (req.command == bspm_pkg::CMD_PEEK);
      offset   <= req.operand[IW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bounded_stack_with_peek_minmax_unit.sv =====
`default_nettype none
// push, pop, top, clear and refused requests: result in the cycle after acceptance
// peek, max and min rotate the whole ring of DEPTH cells once and register the result
// after the last rotation step; next request taken once the result register is free
// one request in flight; a waiting result blocks the next request until taken
// reset clears the fill count and control state; stored words stay undefined
module bounded_stack_with_peek_minmax_unit #(
  parameter int DEPTH = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire bspm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output bspm_pkg::rsp_t      rsp
);

  bspm_pkg::cell_ctl_t cell_ctl;
  logic signed [31:0]  vals [DEPTH];

  bspm_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (vals[0]),
    .cell_ctl  (cell_ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bspm_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .from_above ((i == 0) ? cell_ctl.push_data : vals[(i + DEPTH - 1) % DEPTH]),
      .from_below (vals[(i + 1) % DEPTH]),
      .value      (vals[i])
    );
  end

`ifndef SYNTHESIS
  a_accept_result_or_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (rsp_valid || !req_ready))
    else $error("request accepted but neither result nor busy");

  a_error_zero_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != bspm_pkg::STAT_OK) |-> (rsp.read_data == '0))
    else $error("error status with nonzero data");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == bspm_pkg::STAT_FULL) |-> (rsp.fill_count == 11'(DEPTH)))
    else $error("full status with wrong fill count");
`endif

endmodule
`default_nettype wire
